// ===== rtl/core/tmes_pkg.sv =====
// ----------------------------------------------------------------------------
// tmes_pkg
// shared constants for the timed midi event scheduler
// ----------------------------------------------------------------------------
package tmes_pkg;

   localparam int POOL_DEPTH = 1024;
   localparam int PORT_COUNT = 32;

   localparam int SLOT_W = $clog2(POOL_DEPTH);
   localparam int LINK_W = SLOT_W + 1;
   localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(POOL_DEPTH);

   localparam int TIME_W  = 48;
   localparam int PORT_W  = 5;
   localparam int LEN_W   = 2;
   localparam int BYTES_W = 24;
   localparam int FRAME_W = 14;
   localparam int OFFS_W  = 13;
   localparam int DATA_W  = TIME_W + PORT_W + LEN_W + BYTES_W;

   localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(PORT_COUNT - 1);
   localparam logic [OFFS_W-1:0] OFFSET_MAX = {OFFS_W{1'b1}};

   localparam logic [1:0] STATUS_QUEUED  = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_EMITTED = 2'd2;
   localparam logic [1:0] STATUS_CLOSED  = 2'd3;

   localparam logic MODE_SCHEDULE = 1'b0;
   localparam logic MODE_SERVICE  = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]  due_time;
      logic [PORT_W-1:0]  port;
      logic [LEN_W-1:0]   len;
      logic [BYTES_W-1:0] bytes;
   } entry_type;

endpackage

// ===== rtl/core/tmes_ram.sv =====
// ----------------------------------------------------------------------------
// tmes_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tmes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/timed_midi_event_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// timed_midi_event_scheduler_unit
// time-sorted event pool kept as a linked list in block ram
// ----------------------------------------------------------------------------
// schedule: accept, free scan (one slot per cycle on the used-map ram),
//   list walk (a head read and a compare per entry passed), then link, a
//   predecessor link when the new entry is not the head, and result
// service: head read, compare, result; an empty list skips the compare
// one item in flight; the next transfer is taken in the cycle after the result is handed over
// reset: a clearing pass over every slot of the used map, no item taken
// ----------------------------------------------------------------------------
module timed_midi_event_scheduler_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [tmes_pkg::PORT_W-1:0]   req_port,
   input  logic [tmes_pkg::TIME_W-1:0]   req_due_time,
   input  logic [tmes_pkg::LEN_W-1:0]    req_msg_len,
   input  logic [tmes_pkg::BYTES_W-1:0]  req_msg_bytes,
   input  logic [tmes_pkg::FRAME_W-1:0]  req_frames,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [tmes_pkg::PORT_W-1:0]   rsp_out_port,
   output logic [tmes_pkg::OFFS_W-1:0]   rsp_frame_offset,
   output logic [tmes_pkg::LEN_W-1:0]    rsp_out_len,
   output logic [tmes_pkg::BYTES_W-1:0]  rsp_out_bytes
);

   localparam int SW = tmes_pkg::SLOT_W;
   localparam int LW = tmes_pkg::LINK_W;

   // sequencer states
   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_FREE      = 4'd2;
   localparam logic [3:0] ST_WALK      = 4'd3;
   localparam logic [3:0] ST_WALK_CHK  = 4'd4;
   localparam logic [3:0] ST_LINK      = 4'd5;
   localparam logic [3:0] ST_LINK_PREV = 4'd6;
   localparam logic [3:0] ST_SVC_RD    = 4'd7;
   localparam logic [3:0] ST_SVC_CHK   = 4'd8;
   localparam logic [3:0] ST_RESP      = 4'd9;

   logic [3:0] state_ff, state_in;

   // latched item
   logic                       mode_ff, mode_in;
   tmes_pkg::entry_type        item_ff, item_in;
   logic [tmes_pkg::FRAME_W-1:0] frames_ff, frames_in;

   // list and time state
   logic [LW-1:0]              head_ff, head_in;
   logic [tmes_pkg::TIME_W-1:0] running_ff, running_in;

   // scan and walk pointers
   logic [SW-1:0] clr_ff, clr_in;
   logic [SW:0]   scan_ff, scan_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] chk_ff, chk_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] prev_ff, prev_in;

   // pending result
   logic [1:0]                    res_status_ff, res_status_in;
   logic [tmes_pkg::PORT_W-1:0]   res_port_ff, res_port_in;
   logic [tmes_pkg::OFFS_W-1:0]   res_offs_ff, res_offs_in;
   logic [tmes_pkg::LEN_W-1:0]    res_len_ff, res_len_in;
   logic [tmes_pkg::BYTES_W-1:0]  res_bytes_ff, res_bytes_in;

   // output register
   logic                          out_valid_ff, out_valid_in;
   logic [1:0]                    out_status_ff, out_status_in;
   logic [tmes_pkg::PORT_W-1:0]   out_port_ff, out_port_in;
   logic [tmes_pkg::OFFS_W-1:0]   out_offs_ff, out_offs_in;
   logic [tmes_pkg::LEN_W-1:0]    out_len_ff, out_len_in;
   logic [tmes_pkg::BYTES_W-1:0]  out_bytes_ff, out_bytes_in;

   // ram ports
   logic                      data_we;
   logic [SW-1:0]             data_waddr, data_raddr;
   tmes_pkg::entry_type       data_wdata, data_rdata;
   logic [tmes_pkg::DATA_W-1:0] data_rraw;
   logic                      link_we;
   logic [SW-1:0]             link_waddr;
   logic [LW-1:0]             link_wdata, link_rdata;
   logic                      used_we;
   logic [SW-1:0]             used_waddr, used_raddr;
   logic                      used_wdata, used_rdata;

   // service arithmetic
   logic [tmes_pkg::TIME_W:0]   frame_end;
   logic                        head_due;
   logic [tmes_pkg::TIME_W-1:0] diff;
   logic [tmes_pkg::OFFS_W-1:0] offs;

   logic req_xfer, out_free;

   assign req_xfer = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !out_valid_ff || rsp_ready;
   assign data_rdata = tmes_pkg::entry_type'(data_rraw);

   assign frame_end = {1'b0, running_ff}
                    + (tmes_pkg::TIME_W+1)'(frames_ff);
   assign head_due = ({1'b0, data_rdata.due_time} < frame_end);
   assign diff = data_rdata.due_time - running_ff;
   always_comb begin
      if (data_rdata.due_time <= running_ff) begin
         offs = '0;  // late or on-time event
      end else if (diff[tmes_pkg::TIME_W-1:tmes_pkg::OFFS_W] != '0) begin
         offs = tmes_pkg::OFFSET_MAX;
      end else begin
         offs = diff[tmes_pkg::OFFS_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      item_in       = item_ff;
      frames_in     = frames_ff;
      head_in       = head_ff;
      running_in    = running_ff;
      clr_in        = clr_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      chk_in        = chk_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      res_status_in = res_status_ff;
      res_port_in   = res_port_ff;
      res_offs_in   = res_offs_ff;
      res_len_in    = res_len_ff;
      res_bytes_in  = res_bytes_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_port_in   = out_port_ff;
      out_offs_in   = out_offs_ff;
      out_len_in    = out_len_ff;
      out_bytes_in  = out_bytes_ff;

      data_we    = 1'b0;
      data_waddr = slot_ff;
      data_wdata = item_ff;
      data_raddr = cur_ff[SW-1:0];
      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = cur_ff;
      used_we    = 1'b0;
      used_waddr = slot_ff;
      used_wdata = 1'b1;
      used_raddr = scan_ff[SW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // wipe the used map one slot per cycle
            used_we    = 1'b1;
            used_waddr = clr_ff;
            used_wdata = 1'b0;
            clr_in     = clr_ff + SW'(1);
            if (clr_ff == SW'(tmes_pkg::POOL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in          = req_mode;
               item_in.due_time = req_due_time;
               item_in.port     = (int'(req_port) >= tmes_pkg::PORT_COUNT)
                                  ? tmes_pkg::PORT_MAX : req_port;
               item_in.len      = req_msg_len;
               item_in.bytes    = req_msg_bytes;
               frames_in        = req_frames;
               scan_in          = '0;
               cur_in           = head_ff;
               prev_in          = tmes_pkg::NIL_SLOT;
               res_port_in      = '0;
               res_offs_in      = '0;
               res_len_in       = '0;
               res_bytes_in     = '0;
               if (req_mode == tmes_pkg::MODE_SCHEDULE) begin
                  state_in = ST_FREE;
               end else begin
                  state_in = ST_SVC_RD;
               end
            end
         end
         ST_FREE: begin
            // pipelined scan: issue one address, check the one before
            pend_in = (scan_ff < (SW+1)'(tmes_pkg::POOL_DEPTH));
            chk_in  = scan_ff[SW-1:0];
            scan_in = pend_in ? scan_ff + (SW+1)'(1) : scan_ff;
            if (pend_ff && !used_rdata) begin
               slot_in  = chk_ff;
               state_in = ST_WALK;
            end else if (!pend_ff && (scan_ff == (SW+1)'(tmes_pkg::POOL_DEPTH))) begin
               res_status_in = tmes_pkg::STATUS_DROPPED;
               state_in      = ST_RESP;
            end
         end
         ST_WALK: begin
            if (cur_ff == tmes_pkg::NIL_SLOT) begin
               state_in = ST_LINK;
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            // equal times go behind, keeping arrival order
            if (data_rdata.due_time <= item_ff.due_time) begin
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               state_in = ST_WALK;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            data_we = 1'b1;
            link_we = 1'b1;
            used_we = 1'b1;
            res_status_in = tmes_pkg::STATUS_QUEUED;
            if (prev_ff == tmes_pkg::NIL_SLOT) begin
               head_in  = {1'b0, slot_ff};
               state_in = ST_RESP;
            end else begin
               state_in = ST_LINK_PREV;
            end
         end
         ST_LINK_PREV: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[SW-1:0];
            link_wdata = {1'b0, slot_ff};
            state_in   = ST_RESP;
         end
         ST_SVC_RD: begin
            if (head_ff == tmes_pkg::NIL_SLOT) begin
               running_in    = frame_end[tmes_pkg::TIME_W-1:0];
               res_status_in = tmes_pkg::STATUS_CLOSED;
               state_in      = ST_RESP;
            end else begin
               state_in = ST_SVC_CHK;
            end
         end
         ST_SVC_CHK: begin
            if (head_due) begin
               used_we       = 1'b1;
               used_waddr    = head_ff[SW-1:0];
               used_wdata    = 1'b0;
               head_in       = link_rdata;
               res_status_in = tmes_pkg::STATUS_EMITTED;
               res_port_in   = data_rdata.port;
               res_offs_in   = offs;
               res_len_in    = data_rdata.len;
               res_bytes_in  = data_rdata.bytes;
            end else begin
               running_in    = frame_end[tmes_pkg::TIME_W-1:0];
               res_status_in = tmes_pkg::STATUS_CLOSED;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hand over to the output register once it is free
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_port_in   = res_port_ff;
               out_offs_in   = res_offs_ff;
               out_len_in    = res_len_ff;
               out_bytes_in  = res_bytes_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // service reads address the head slot
      if (state_ff == ST_SVC_RD || (state_ff == ST_IDLE && req_xfer)) begin
         data_raddr = head_ff[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         head_ff      <= tmes_pkg::NIL_SLOT;
         running_ff   <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         running_ff   <= running_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      mode_ff       <= mode_in;
      item_ff       <= item_in;
      frames_ff     <= frames_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_port_ff   <= res_port_in;
      res_offs_ff   <= res_offs_in;
      res_len_ff    <= res_len_in;
      res_bytes_ff  <= res_bytes_in;
      out_status_ff <= out_status_in;
      out_port_ff   <= out_port_in;
      out_offs_ff   <= out_offs_in;
      out_len_ff    <= out_len_in;
      out_bytes_ff  <= out_bytes_in;
   end

   // entry payload: time, port, length, bytes
   tmes_ram #(
      .WIDTH (tmes_pkg::DATA_W),
      .DEPTH (tmes_pkg::POOL_DEPTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_addr (data_raddr),
      .rd_data (data_rraw)
   );

   // next pointers, written apart from the payload
   tmes_ram #(
      .WIDTH (LW),
      .DEPTH (tmes_pkg::POOL_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (data_raddr),
      .rd_data (link_rdata)
   );

   // one used bit per slot
   tmes_ram #(
      .WIDTH (1),
      .DEPTH (tmes_pkg::POOL_DEPTH)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_waddr),
      .wr_data (used_wdata),
      .rd_addr (used_raddr),
      .rd_data (used_rdata)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_out_port     = out_port_ff;
   assign rsp_frame_offset = out_offs_ff;
   assign rsp_out_len      = out_len_ff;
   assign rsp_out_bytes    = out_bytes_ff;

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after an input transfer");

   a_prev_linked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK_PREV) |-> (prev_ff != tmes_pkg::NIL_SLOT))
      else $error("predecessor update without a predecessor");

   a_head_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SVC_CHK) |-> (head_ff != tmes_pkg::NIL_SLOT))
      else $error("service check on an empty list");

   a_mode_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SVC_CHK) |-> (mode_ff == tmes_pkg::MODE_SERVICE))
      else $error("schedule item on the service path");
`endif

endmodule

// ===== dv/tb_timed_midi_event_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_timed_midi_event_scheduler_unit
// self-checking bench for the timed midi event scheduler: directed and random
// schedule and service transfers, a sorted-pool predictor, checks on every
// result field, random gaps on both sides and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_timed_midi_event_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tmes_pkg::*;

   localparam int CYCLE_LIMIT = 10000000;
   localparam int NIL = POOL_DEPTH;

   typedef struct packed {
      logic               mode;
      logic [PORT_W-1:0]  port;
      logic [TIME_W-1:0]  due_time;
      logic [LEN_W-1:0]   msg_len;
      logic [BYTES_W-1:0] msg_bytes;
      logic [FRAME_W-1:0] frames;
   } midi_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [PORT_W-1:0]  port;
      logic [OFFS_W-1:0]  offset;
      logic [LEN_W-1:0]   len;
      logic [BYTES_W-1:0] bytes;
   } midi_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic [PORT_W-1:0] req_port = '0;
   logic [TIME_W-1:0] req_due_time = '0;
   logic [LEN_W-1:0] req_msg_len = '0;
   logic [BYTES_W-1:0] req_msg_bytes = '0;
   logic [FRAME_W-1:0] req_frames = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [PORT_W-1:0] rsp_out_port;
   logic [OFFS_W-1:0] rsp_frame_offset;
   logic [LEN_W-1:0] rsp_out_len;
   logic [BYTES_W-1:0] rsp_out_bytes;

   timed_midi_event_scheduler_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_port(req_port), .req_due_time(req_due_time), .req_msg_len(req_msg_len),
      .req_msg_bytes(req_msg_bytes), .req_frames(req_frames),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_port(rsp_out_port), .rsp_frame_offset(rsp_frame_offset),
      .rsp_out_len(rsp_out_len), .rsp_out_bytes(rsp_out_bytes)
   );

   always #2 clock = ~clock;

   // predictor state: shadow pool kept as a sorted linked list
   logic [TIME_W-1:0]  pool_time [POOL_DEPTH];
   logic [PORT_W-1:0]  pool_port [POOL_DEPTH];
   logic [LEN_W-1:0]   pool_len [POOL_DEPTH];
   logic [BYTES_W-1:0] pool_bytes [POOL_DEPTH];
   int                 pool_link [POOL_DEPTH];
   bit                 pool_used [POOL_DEPTH];
   int                 list_head = NIL;
   int                 pool_count = 0;
   logic [TIME_W-1:0]  now_time = '0;

   midi_req_type pending_reqs[$];
   midi_rsp_type expected_rsps[$];
   int  mismatches = 0;
   int  rsp_count = 0;
   int  emitted_count = 0;
   int  dropped_count = 0;
   int  cycle_count = 0;
   bit  stim_done = 1'b0;
   int  hold_off = 0;
   bit  hold_armed = 1'b0;

   // apply one accepted transfer to the shadow pool, return what it yields
   function automatic midi_rsp_type schedule_predict(midi_req_type r);
      midi_rsp_type  res;
      int         slot, prev, cur;
      logic [PORT_W-1:0] p;
      logic [TIME_W+FRAME_W:0] limit;
      logic [TIME_W-1:0] diff;
      res = '0;
      if (r.mode == MODE_SCHEDULE) begin
         slot = NIL;
         for (int i = 0; i < POOL_DEPTH; i++) begin
            if (!pool_used[i]) begin
               slot = i;
               break;
            end
         end
         if (slot == NIL) begin
            res.status = STATUS_DROPPED;
            return res;
         end
         p = (r.port >= PORT_COUNT) ? PORT_MAX : r.port;
         prev = NIL;
         cur = list_head;
         while (cur != NIL && pool_time[cur] <= r.due_time) begin
            prev = cur;
            cur = pool_link[cur];
         end
         pool_time[slot] = r.due_time;
         pool_port[slot] = p;
         pool_len[slot] = r.msg_len;
         pool_bytes[slot] = r.msg_bytes;
         pool_link[slot] = cur;
         pool_used[slot] = 1'b1;
         if (prev != NIL) pool_link[prev] = slot;
         else list_head = slot;
         pool_count++;
         res.status = STATUS_QUEUED;
         return res;
      end
      // due test is done without wrapping the sum
      limit = {1'b0, now_time} + r.frames;
      if (list_head != NIL && {1'b0, pool_time[list_head]} < limit) begin
         cur = list_head;
         diff = (pool_time[cur] > now_time) ? pool_time[cur] - now_time : '0;
         res.status = STATUS_EMITTED;
         res.port = pool_port[cur];
         res.offset = (diff > OFFSET_MAX) ? OFFSET_MAX : diff[OFFS_W-1:0];
         res.len = pool_len[cur];
         res.bytes = pool_bytes[cur];
         pool_used[cur] = 1'b0;
         list_head = pool_link[cur];
         pool_count--;
         return res;
      end
      now_time = now_time + r.frames;
      res.status = STATUS_CLOSED;
      return res;
   endfunction

   function automatic midi_req_type make_sched(logic [TIME_W-1:0] t);
      midi_req_type r;
      r.mode = MODE_SCHEDULE;
      r.port = PORT_W'($urandom);
      r.due_time = t;
      r.msg_len = LEN_W'($urandom);
      r.msg_bytes = BYTES_W'($urandom);
      r.frames = FRAME_W'($urandom);
      return r;
   endfunction

   function automatic midi_req_type make_service(logic [FRAME_W-1:0] f);
      midi_req_type r;
      r = make_sched('0);
      r.mode = MODE_SERVICE;
      r.due_time = TIME_W'({$urandom, $urandom});
      r.frames = f;
      return r;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver: offers queued transfers with random gaps
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(schedule_predict(pending_reqs.pop_front()));
            send_gap = gap_len();
         end
         if ((!req_valid || req_ready) && send_gap == 0 && pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            {req_mode, req_port, req_due_time, req_msg_len, req_msg_bytes, req_frames}
               <= pending_reqs[0];
         end else if (req_valid && req_ready) begin
            req_valid <= 1'b0;
         end
         if (send_gap > 0 && !(req_valid && !req_ready)) send_gap--;
      end
   end

   // receiver: random stalls plus one long hold-off once the pool gets busy
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_armed && pool_count > 8) begin
            hold_armed = 1'b1;
            hold_off = 400;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 25) ? 1'b0 : 1'b1;
         end
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      midi_rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_status, rsp_out_port, rsp_frame_offset, rsp_out_len, rsp_out_bytes};
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (want.status == STATUS_EMITTED) emitted_count++;
            if (want.status == STATUS_DROPPED) dropped_count++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d mismatch: expected %p, got %p", rsp_count, want, got);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] base;
      midi_req_type r;
      for (int i = 0; i < POOL_DEPTH; i++) pool_used[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, equal times, late event, zero frame, wide frame
      r = make_sched('0);
      r.port = '1; r.msg_len = '0; r.msg_bytes = '1;
      pending_reqs.push_back(r);
      r = make_sched({TIME_W{1'b1}});
      r.port = '0; r.msg_len = 2'd3; r.msg_bytes = '0;
      pending_reqs.push_back(r);
      for (int i = 0; i < 3; i++) pending_reqs.push_back(make_sched(48'd100));
      pending_reqs.push_back(make_sched(48'd20000));
      pending_reqs.push_back(make_service(14'd0));
      pending_reqs.push_back(make_service(14'd0));
      pending_reqs.push_back(make_service(14'd50));
      pending_reqs.push_back(make_service(14'd200));
      for (int i = 0; i < 4; i++) pending_reqs.push_back(make_service(14'd200));
      pending_reqs.push_back(make_service(14'h3FFF));
      pending_reqs.push_back(make_service(14'h3FFF));
      pending_reqs.push_back(make_service(14'd1));
      pending_reqs.push_back(make_service(14'd8192));
      pending_reqs.push_back(make_service(14'd8192));
      pending_reqs.push_back(make_sched(48'd5));
      pending_reqs.push_back(make_service(14'd1));

      // random: bursts of near-future schedules, then frame servicing
      base = 48'd0;
      for (int n = 0; n < 560; ) begin
         int burst;
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst; b++, n++) begin
            if ($urandom_range(0, 19) == 0)
               pending_reqs.push_back(make_sched(TIME_W'({$urandom, $urandom})));
            else
               pending_reqs.push_back(make_sched(base + $urandom_range(0, 3000)));
         end
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst; b++, n++)
            pending_reqs.push_back(make_service($urandom_range(0, 3) == 0 ?
               14'($urandom) : 14'($urandom_range(1, 1024))));
         base = base + $urandom_range(0, 1500);
      end

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (3000) @(posedge clock);
      $display("%0d results checked, %0d events emitted, %0d drops, %0d still pooled",
               rsp_count, emitted_count, dropped_count, pool_count);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
